// File: hdl/gcd_pair_count_in_rectangle_defines.svh
// assertion helpers for the gcd pair counter
`ifndef GCD_PAIR_COUNT_IN_RECTANGLE_DEFINES_SVH
`define GCD_PAIR_COUNT_IN_RECTANGLE_DEFINES_SVH
`define GPC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hdl/gpc_pkg.sv
package gpc_pkg;
    localparam int MaxValue = 65535;
    localparam int ValW = 16;
    localparam int AddrW = 16;
    localparam int Depth = MaxValue + 1;
    localparam int CntW = 33;
    localparam int AccW = 36;

    // divider operand selects
    localparam logic [2:0] DivCn  = 3'd0;
    localparam logic [2:0] DivCm  = 3'd1;
    localparam logic [2:0] DivNi  = 3'd2;
    localparam logic [2:0] DivMi  = 3'd3;
    localparam logic [2:0] DivNq  = 3'd4;
    localparam logic [2:0] DivMq  = 3'd5;
    localparam logic [2:0] DivMod = 3'd6;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_SV_I, ST_SV_IRD, ST_SV_J, ST_SV_PRD, ST_SV_PRD2, ST_SV_MUL,
        ST_SV_MOD, ST_SV_MODW, ST_SV_WR, ST_SV_NEXTI, ST_PF_RD, ST_PF_RDW, ST_PF_WR,
        ST_IDLE, ST_CORNER, ST_DIVN, ST_DIVM, ST_SWAP, ST_BLK, ST_QN, ST_QM, ST_JN,
        ST_JM, ST_MRD, ST_MRDW, ST_MACC, ST_MACC2, ST_NEXTC, ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic sv_start;
        logic sv_rdi;
        logic sv_prd;
        logic sv_mul;
        logic sv_wr;
        logic sv_nexti;
        logic sv_nextj;
        logic pf_wr;
        logic load;
        logic corner_init;
        logic div_start;
        logic [2:0] div_sel;
        logic swap;
        logic blk_init;
        logic mrd;
        logic macc;
        logic macc2;
        logic blk_next;
        logic corner_next;
        logic out_set;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic i_composite;
        logic j_end;
        logic prod_big;
        logic divides;
        logic sieve_done;
        logic pf_done;
        logic div_done;
        logic empty;
        logic blk_done;
        logic corners_done;
    } sts_t;
endpackage

// File: hdl/gpc_ram.sv
module gpc_ram #(
    parameter int Width = 16,
    parameter int Depth = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/gpc_div.sv
// restoring divider, one quotient bit per cycle
module gpc_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [gpc_pkg::ValW-1:0] num,
    input  logic [gpc_pkg::ValW-1:0] den,
    output logic                    done,
    output logic [gpc_pkg::ValW-1:0] quo,
    output logic [gpc_pkg::ValW-1:0] rem
);
    localparam int W = gpc_pkg::ValW;
    logic [W-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [$clog2(W+1)-1:0] n_reg, n_next;
    logic busy_reg, busy_next;
    logic [W:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        if (start) begin
            q_next = num;
            r_next = '0;
            d_next = den;
            n_next = ($clog2(W+1))'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == ($clog2(W+1))'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = !busy_reg;
    assign quo = q_reg;
    assign rem = r_reg;
endmodule

// File: hdl/gpc_datapath.sv
module gpc_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  gpc_pkg::cmd_t       cmd,
    output gpc_pkg::sts_t       sts,
    input  logic [79:0]         in_data,
    output logic [gpc_pkg::CntW-1:0] result
);
    localparam int W = gpc_pkg::ValW;
    localparam int AW = gpc_pkg::AddrW;
    localparam int D = gpc_pkg::Depth;
    localparam int AC = gpc_pkg::AccW;

    // sieve memories: mobius/flag table, prime list, prefix table
    logic mu_we, pr_we, mp_we;
    logic [AW-1:0] mu_wa, mu_ra, pr_wa, pr_ra, mp_wa, mp_ra;
    logic [2:0] mu_wd, mu_rd;
    logic [W-1:0] pr_wd, pr_rd, mp_wd, mp_rd;

    // mu table entry: {composite, mu[1:0] two's complement}
    gpc_ram #(.Width(3), .Depth(D)) u_mu (.aclk, .we(mu_we), .waddr(mu_wa), .wdata(mu_wd),
        .raddr(mu_ra), .rdata(mu_rd));
    gpc_ram #(.Width(W), .Depth(D)) u_pr (.aclk, .we(pr_we), .waddr(pr_wa), .wdata(pr_wd),
        .raddr(pr_ra), .rdata(pr_rd));
    gpc_ram #(.Width(W), .Depth(D)) u_mp (.aclk, .we(mp_we), .waddr(mp_wa), .wdata(mp_wd),
        .raddr(mp_ra), .rdata(mp_rd));

    logic [AW:0] ci_reg;          // clear / sieve i / prefix index
    logic [AW-1:0] cnt_reg, j_reg;
    logic [1:0] mui_reg;
    logic [W-1:0] p_reg;
    logic [2*W-1:0] prod_reg;
    logic [W-1:0] acc_reg;

    logic [W-1:0] a_reg, b_reg, c_reg, d_reg, k_reg;
    logic [1:0] corner_reg;
    logic [W-1:0] n_reg, m_reg, i_reg, qn_reg, qm_reg, jn_reg, mi_reg;
    logic signed [W:0] dm_reg;
    logic signed [AC-1:0] pm_reg;
    logic [2*W-1:0] qq_reg;

    logic div_start;
    logic [W-1:0] dnum, dden, dquo, drem;
    logic div_done;
    gpc_div u_div (.aclk, .aresetn, .start(div_start), .num(dnum), .den(dden),
        .done(div_done), .quo(dquo), .rem(drem));

    logic [W-1:0] a1, c1, cn, cm, jmin;
    always_comb begin
        a1 = (a_reg == '0) ? W'(1) : a_reg;
        c1 = (c_reg == '0) ? W'(1) : c_reg;
        unique case (corner_reg)
            2'd0: begin cn = b_reg; cm = d_reg; end
            2'd1: begin cn = a1 - 1'b1; cm = d_reg; end
            2'd2: begin cn = b_reg; cm = c1 - 1'b1; end
            default: begin cn = a1 - 1'b1; cm = c1 - 1'b1; end
        endcase
        jmin = (jn_reg < dquo) ? jn_reg : dquo;
    end

    always_comb begin
        div_start = cmd.div_start;
        unique case (cmd.div_sel)
            gpc_pkg::DivCn: begin dnum = cn; dden = k_reg; end
            gpc_pkg::DivCm: begin dnum = cm; dden = k_reg; end
            gpc_pkg::DivNi: begin dnum = n_reg; dden = i_reg; end
            gpc_pkg::DivMi: begin dnum = m_reg; dden = i_reg; end
            gpc_pkg::DivNq: begin dnum = n_reg; dden = qn_reg; end
            gpc_pkg::DivMq: begin dnum = m_reg; dden = qm_reg; end
            default: begin dnum = ci_reg[W-1:0]; dden = p_reg; end
        endcase
    end

    always_comb begin
        mu_we = 1'b0; mu_wa = ci_reg[AW-1:0]; mu_wd = 3'b000;
        mu_ra = ci_reg[AW-1:0];
        pr_we = 1'b0; pr_wa = cnt_reg; pr_wd = ci_reg[W-1:0]; pr_ra = j_reg;
        mp_we = 1'b0; mp_wa = ci_reg[AW-1:0]; mp_wd = acc_reg; mp_ra = ci_reg[AW-1:0];
        if (cmd.clear_step) begin
            mu_we = 1'b1;
            mu_wd = (ci_reg[AW-1:0] == AW'(1)) ? 3'b001 : 3'b000;
        end
        if (cmd.sv_start) begin
            mu_we = 1'b1; mu_wd = 3'b011; pr_we = 1'b1;
        end
        if (cmd.sv_mul || cmd.sv_wr) begin
            mu_wa = prod_reg[AW-1:0];
        end
        if (cmd.sv_wr) begin
            mu_we = 1'b1;
            mu_wd = sts.divides ? 3'b100 : {1'b1, -mui_reg};
        end
        if (cmd.pf_wr) begin
            mp_we = 1'b1;
            mp_wd = acc_reg + {{(W-2){mu_rd[1]}}, mu_rd[1:0]};
        end
        if (cmd.mrd || cmd.macc) begin
            mp_ra = (cmd.mrd) ? jmin : mi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ci_reg <= '0;
            cnt_reg <= '0;
            corner_reg <= '0;
        end else begin
            if (cmd.clear_step) begin
                ci_reg <= (ci_reg == (AW+1)'(D - 1)) ? (AW+1)'(2) : ci_reg + 1'b1;
            end
            if (cmd.sv_start) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            // prefix pass starts at entry zero
            if (cmd.sv_nexti) begin
                ci_reg <= (ci_reg == (AW+1)'(D - 1)) ? (AW+1)'(0) : ci_reg + 1'b1;
            end
            if (cmd.pf_wr) begin
                ci_reg <= ci_reg + 1'b1;
            end
            if (cmd.corner_init) begin
                corner_reg <= '0;
            end
            if (cmd.corner_next) begin
                corner_reg <= corner_reg + 1'b1;
            end
        end
        if (cmd.sv_rdi) begin
            // a fresh prime gets mu = -1 in the same cycle
            mui_reg <= sts.i_composite ? mu_rd[1:0] : 2'b11;
            j_reg <= '0;
        end
        if (cmd.sv_nextj) begin
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.sv_prd) begin
            p_reg <= pr_rd;
        end
        if (cmd.sv_mul) begin
            prod_reg <= ci_reg[W-1:0] * p_reg;
        end
        if (cmd.sv_nexti && ci_reg == (AW+1)'(D - 1)) begin
            acc_reg <= '0;
        end
        if (cmd.pf_wr) begin
            acc_reg <= mp_wd;
        end
        if (cmd.load) begin
            {k_reg, d_reg, c_reg, b_reg, a_reg} <= in_data;
        end
        if (cmd.div_start && cmd.div_sel == gpc_pkg::DivCm) begin
            n_reg <= dquo;
        end
        if (cmd.swap) begin
            if (dquo < n_reg) begin
                n_reg <= dquo; m_reg <= n_reg;
            end else begin
                m_reg <= dquo;
            end
        end
        if (cmd.blk_init) begin
            i_reg <= W'(1);
        end
        if (cmd.div_start && cmd.div_sel == gpc_pkg::DivMi) begin
            qn_reg <= dquo;
        end
        if (cmd.div_start && cmd.div_sel == gpc_pkg::DivNq) begin
            qm_reg <= dquo;
        end
        if (cmd.div_start && cmd.div_sel == gpc_pkg::DivMq) begin
            jn_reg <= dquo;
        end
        if (cmd.mrd) begin
            jn_reg <= jmin;
            mi_reg <= i_reg - 1'b1;
            qq_reg <= qn_reg * qm_reg;
        end
        if (cmd.macc) begin
            dm_reg <= $signed({mp_rd[W-1], mp_rd});
        end
        if (cmd.macc2) begin
            dm_reg <= dm_reg - $signed({mp_rd[W-1], mp_rd});
        end
        if (cmd.blk_next) begin
            pm_reg <= dm_reg * $signed({1'b0, qq_reg});
            i_reg <= jn_reg + 1'b1;
        end
    end

    // the block loop keeps its own small sequencing register
    logic [1:0] bph_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bph_reg <= '0;
        end else if (cmd.blk_next) begin
            bph_reg <= 2'd1;
        end else if (bph_reg == 2'd1) begin
            bph_reg <= 2'd0;
        end
    end

    logic signed [AC-1:0] add_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            add_reg <= '0;
        end else if (bph_reg == 2'd1) begin
            // corners 1 and 2 subtract
            if (corner_reg == 2'd1 || corner_reg == 2'd2) begin
                add_reg <= add_reg - pm_reg;
            end else begin
                add_reg <= add_reg + pm_reg;
            end
        end
        if (cmd.out_set) begin
            result <= add_reg[AC-1] ? '0 : add_reg[gpc_pkg::CntW-1:0];
        end
    end

    always_comb begin
        sts.clear_done = (ci_reg == (AW+1)'(D - 1));
        sts.i_composite = mu_rd[2];
        sts.j_end = (j_reg == cnt_reg);
        sts.prod_big = (prod_reg > (2*W)'(gpc_pkg::MaxValue));
        sts.divides = (drem == '0);
        sts.sieve_done = (ci_reg == (AW+1)'(D - 1));
        sts.pf_done = (ci_reg == (AW+1)'(D - 1));
        sts.div_done = div_done;
        sts.empty = (k_reg == '0) || (a1 > b_reg) || (c1 > d_reg);
        sts.blk_done = (i_reg > n_reg) || (i_reg == '0);
        sts.corners_done = (corner_reg == 2'd3);
    end
endmodule

// File: hdl/gpc_ctrl.sv
module gpc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          out_fire,
    input  gpc_pkg::sts_t sts,
    output gpc_pkg::cmd_t cmd,
    output logic          in_ready,
    output logic          out_valid
);
    gpc_pkg::state_t state_reg, state_next;
    logic ov_reg, ov_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gpc_pkg::ST_CLEAR: if (sts.clear_done) state_next = gpc_pkg::ST_SV_I;
            gpc_pkg::ST_SV_I: state_next = gpc_pkg::ST_SV_IRD;
            gpc_pkg::ST_SV_IRD: state_next = gpc_pkg::ST_SV_J;
            gpc_pkg::ST_SV_J: state_next = sts.j_end ? gpc_pkg::ST_SV_NEXTI
                                                     : gpc_pkg::ST_SV_PRD;
            gpc_pkg::ST_SV_PRD: state_next = gpc_pkg::ST_SV_PRD2;
            gpc_pkg::ST_SV_PRD2: state_next = gpc_pkg::ST_SV_MUL;
            gpc_pkg::ST_SV_MUL: state_next = gpc_pkg::ST_SV_MOD;
            gpc_pkg::ST_SV_MOD: state_next = sts.prod_big ? gpc_pkg::ST_SV_NEXTI
                                                          : gpc_pkg::ST_SV_MODW;
            gpc_pkg::ST_SV_MODW: if (sts.div_done) state_next = gpc_pkg::ST_SV_WR;
            gpc_pkg::ST_SV_WR: state_next = sts.divides ? gpc_pkg::ST_SV_NEXTI
                                                        : gpc_pkg::ST_SV_J;
            gpc_pkg::ST_SV_NEXTI: state_next = sts.sieve_done ? gpc_pkg::ST_PF_RD
                                                              : gpc_pkg::ST_SV_I;
            gpc_pkg::ST_PF_RD: state_next = gpc_pkg::ST_PF_RDW;
            gpc_pkg::ST_PF_RDW: state_next = gpc_pkg::ST_PF_WR;
            gpc_pkg::ST_PF_WR: state_next = sts.pf_done ? gpc_pkg::ST_IDLE
                                                        : gpc_pkg::ST_PF_RD;
            gpc_pkg::ST_IDLE: if (in_fire) state_next = gpc_pkg::ST_CORNER;
            gpc_pkg::ST_CORNER: state_next = sts.empty ? gpc_pkg::ST_OUT
                                                       : gpc_pkg::ST_DIVN;
            gpc_pkg::ST_DIVN: if (sts.div_done) state_next = gpc_pkg::ST_DIVM;
            gpc_pkg::ST_DIVM: if (sts.div_done) state_next = gpc_pkg::ST_SWAP;
            gpc_pkg::ST_SWAP: if (sts.div_done) state_next = gpc_pkg::ST_BLK;
            gpc_pkg::ST_BLK: state_next = sts.blk_done ? gpc_pkg::ST_NEXTC
                                                       : gpc_pkg::ST_QN;
            gpc_pkg::ST_QN: if (sts.div_done) state_next = gpc_pkg::ST_QM;
            gpc_pkg::ST_QM: if (sts.div_done) state_next = gpc_pkg::ST_JN;
            gpc_pkg::ST_JN: if (sts.div_done) state_next = gpc_pkg::ST_JM;
            gpc_pkg::ST_JM: if (sts.div_done) state_next = gpc_pkg::ST_MRD;
            gpc_pkg::ST_MRD: if (sts.div_done) state_next = gpc_pkg::ST_MRDW;
            gpc_pkg::ST_MRDW: state_next = gpc_pkg::ST_MACC;
            gpc_pkg::ST_MACC: state_next = gpc_pkg::ST_MACC2;
            gpc_pkg::ST_MACC2: state_next = gpc_pkg::ST_BLK;
            gpc_pkg::ST_NEXTC: state_next = sts.corners_done ? gpc_pkg::ST_OUT
                                                             : gpc_pkg::ST_CORNER;
            gpc_pkg::ST_OUT: if (!ov_reg || out_fire) state_next = gpc_pkg::ST_IDLE;
            default: state_next = gpc_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.div_sel = gpc_pkg::DivMod;
        in_ready = 1'b0;
        ov_next = ov_reg && !out_fire;
        unique case (state_reg)
            gpc_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
            gpc_pkg::ST_SV_I: cmd.sv_rdi = 1'b0;
            gpc_pkg::ST_SV_IRD: begin
                cmd.sv_rdi = 1'b1;
                cmd.sv_start = !sts.i_composite;
            end
            gpc_pkg::ST_SV_PRD2: cmd.sv_prd = 1'b1;
            gpc_pkg::ST_SV_MUL: cmd.sv_mul = 1'b1;
            gpc_pkg::ST_SV_MOD: begin
                cmd.div_start = !sts.prod_big;
                cmd.div_sel = gpc_pkg::DivMod;
            end
            gpc_pkg::ST_SV_MODW: cmd.div_sel = gpc_pkg::DivMod;
            gpc_pkg::ST_SV_WR: begin
                cmd.sv_wr = 1'b1;
                cmd.sv_nextj = 1'b1;
                cmd.div_sel = gpc_pkg::DivMod;
            end
            gpc_pkg::ST_SV_NEXTI: cmd.sv_nexti = 1'b1;
            gpc_pkg::ST_PF_WR: cmd.pf_wr = 1'b1;
            gpc_pkg::ST_IDLE: begin
                // the previous result may still wait in its own register
                in_ready = 1'b1;
                cmd.load = in_fire;
                cmd.corner_init = in_fire;
            end
            gpc_pkg::ST_CORNER: begin
                cmd.div_start = !sts.empty;
                cmd.div_sel = gpc_pkg::DivCn;
            end
            gpc_pkg::ST_DIVN: begin
                cmd.div_sel = gpc_pkg::DivCn;
                cmd.div_start = sts.div_done;
                if (sts.div_done) cmd.div_sel = gpc_pkg::DivCm;
            end
            gpc_pkg::ST_DIVM: begin
                cmd.div_sel = gpc_pkg::DivCm;
                cmd.swap = sts.div_done;
                cmd.blk_init = sts.div_done;
            end
            gpc_pkg::ST_BLK: begin
                cmd.div_start = !sts.blk_done;
                cmd.div_sel = gpc_pkg::DivNi;
            end
            gpc_pkg::ST_QN: begin
                cmd.div_sel = gpc_pkg::DivNi;
                cmd.div_start = sts.div_done;
                if (sts.div_done) cmd.div_sel = gpc_pkg::DivMi;
            end
            gpc_pkg::ST_QM: begin
                cmd.div_sel = gpc_pkg::DivMi;
                cmd.div_start = sts.div_done;
                if (sts.div_done) cmd.div_sel = gpc_pkg::DivNq;
            end
            gpc_pkg::ST_JN: begin
                cmd.div_sel = gpc_pkg::DivNq;
                cmd.div_start = sts.div_done;
                if (sts.div_done) cmd.div_sel = gpc_pkg::DivMq;
            end
            gpc_pkg::ST_JM: cmd.div_sel = gpc_pkg::DivMq;
            gpc_pkg::ST_MRD: cmd.mrd = sts.div_done;
            gpc_pkg::ST_MRDW: cmd.macc = 1'b1;
            gpc_pkg::ST_MACC: cmd.macc2 = 1'b1;
            gpc_pkg::ST_MACC2: cmd.blk_next = 1'b1;
            gpc_pkg::ST_NEXTC: cmd.corner_next = !sts.corners_done;
            gpc_pkg::ST_OUT: begin
                if (!ov_reg || out_fire) begin
                    cmd.out_set = 1'b1;
                    ov_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gpc_pkg::ST_CLEAR;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule

// File: hdl/gcd_pair_count_in_rectangle.sv
// channel  | dir | payload
// s_axis   | in  | tdata: x_low, x_high, y_low, y_high, divisor (16 bits each)
// m_axis   | out | tdata: pair_count (33 bits, zero filled to 40)
// after reset the mobius table is cleared, sieved and prefix summed before
// s_tready first rises.
// one query at a time: four corner terms, about 2*sqrt(n/k) blocks each, every
// block costing four divisions on the shared divider.
// a finished result waits in the output register; the next query is taken meanwhile.
module gcd_pair_count_in_rectangle (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // x_low, x_high, y_low, y_high, divisor
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // pair_count, zero fill
);
    gpc_pkg::cmd_t cmd;
    gpc_pkg::sts_t sts;
    logic [gpc_pkg::CntW-1:0] result;

    gpc_ctrl u_ctrl (.aclk, .aresetn, .in_fire(s_tvalid && s_tready),
        .out_fire(m_tvalid && m_tready), .sts, .cmd, .in_ready(s_tready),
        .out_valid(m_tvalid));
    gpc_datapath u_dp (.aclk, .aresetn, .cmd, .sts, .in_data(s_tdata), .result);

    assign m_tdata = {7'd0, result};
endmodule

// File: hdl/gpc_checker.sv
`include "gcd_pair_count_in_rectangle_defines.svh"
module gpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    `GPC_ASSERT_NEXT(out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `GPC_ASSERT_IMPL(fill_zero, aclk, aresetn, m_tvalid, m_tdata[39:33] == 7'd0)
    `GPC_ASSERT_NEXT(one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind gcd_pair_count_in_rectangle gpc_checker u_gpc_checker (.*);

// File: bench/tb_gcd_pair_count_in_rectangle.sv
`timescale 1ns / 100ps

module tb_gcd_pair_count_in_rectangle;
    typedef struct packed {
        logic [15:0] divisor;
        logic [15:0] y_high;
        logic [15:0] y_low;
        logic [15:0] x_high;
        logic [15:0] x_low;
    } query_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    gcd_pair_count_in_rectangle DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    query_t          pending_queries[$];
    logic [32:0]     expected_counts[$];
    int              mertens[0:gpc_pkg::MaxValue];
    logic            running = 1'b0;
    logic            fill_done = 1'b0;
    logic            s_took = 1'b0;
    int              s_gap = 0;
    int              m_gap = 0;
    int              errors = 0;
    int              queries_sent = 0;
    int              counts_seen = 0;

    // no idling once the queue runs low
    function automatic bit in_tail();
        return fill_done && (pending_queries.size() < 15);
    endfunction

    // linear sieve for the mobius function, then prefix sums
    task automatic build_mertens();
        int          mu[0:gpc_pkg::MaxValue];
        bit          composite[0:gpc_pkg::MaxValue];
        int          primes[$];
        int          p;
        for (int i = 0; i <= gpc_pkg::MaxValue; i++) begin
            mu[i] = 0;
            composite[i] = 1'b0;
        end
        mu[1] = 1;
        for (int i = 2; i <= gpc_pkg::MaxValue; i++) begin
            if (!composite[i]) begin
                primes.push_back(i);
                mu[i] = -1;
            end
            foreach (primes[j]) begin
                p = primes[j];
                if (i * p > gpc_pkg::MaxValue) break;
                composite[i * p] = 1'b1;
                if (i % p == 0) begin
                    mu[i * p] = 0;
                    break;
                end
                mu[i * p] = -mu[i];
            end
        end
        mertens[0] = 0;
        for (int i = 1; i <= gpc_pkg::MaxValue; i++) mertens[i] = mertens[i - 1] + mu[i];
    endtask

    function automatic longint coprime_pairs(int n, int m, int k);
        longint sum;
        int     t, i, j, qn, qm, jn, jm;
        sum = 0;
        n = n / k;
        m = m / k;
        if (n > m) begin
            t = n;
            n = m;
            m = t;
        end
        i = 1;
        while (i <= n) begin
            qn = n / i;
            qm = m / i;
            jn = n / qn;
            jm = m / qm;
            j = (jn < jm) ? jn : jm;
            sum += longint'(mertens[j] - mertens[i - 1]) * qn * qm;
            i = j + 1;
        end
        return sum;
    endfunction

    function automatic logic [32:0] gcd_pair_count(query_t q);
        int     a, b, c, d, k;
        longint total;
        a = q.x_low;
        b = q.x_high;
        c = q.y_low;
        d = q.y_high;
        k = q.divisor;
        if (a == 0) a = 1;
        if (c == 0) c = 1;
        if (k == 0 || a > b || c > d) return '0;
        total = coprime_pairs(b, d, k) - coprime_pairs(a - 1, d, k)
              - coprime_pairs(b, c - 1, k) + coprime_pairs(a - 1, c - 1, k);
        if (total < 0) total = 0;
        return total[32:0];
    endfunction

    function automatic query_t mk(int a, int b, int c, int d, int k);
        query_t q;
        q.x_low = 16'(a);
        q.x_high = 16'(b);
        q.y_low = 16'(c);
        q.y_high = 16'(d);
        q.divisor = 16'(k);
        return q;
    endfunction

    // pick lo/hi under a ceiling, occasionally reversed for an empty range
    function automatic void rand_range(int top, output int lo, output int hi);
        lo = $urandom_range(0, top);
        hi = $urandom_range(lo, top);
        if ($urandom_range(0, 9) == 0) begin
            int t = lo;
            lo = hi;
            hi = t;
            if (lo == hi) lo = hi + 1;
        end
    endfunction

    // input side: a transfer at the last rising edge frees the bus
    always @(negedge aclk) begin
        logic   nv;
        query_t q;
        if (running) begin
            nv = s_tvalid;
            if (!s_tvalid || s_took) begin
                nv = 1'b0;
                if (s_gap > 0) begin
                    s_gap--;
                end else if (pending_queries.size() > 0) begin
                    if (!in_tail() && $urandom_range(0, 5) == 0) begin
                        s_gap = $urandom_range(1, 12) - 1;
                    end else begin
                        q = pending_queries.pop_front();
                        s_tdata <= q;
                        nv = 1'b1;
                    end
                end
            end
            s_took = 1'b0;
            s_tvalid <= nv;
        end
    end

    always @(negedge aclk) begin
        logic r;
        if (running) begin
            r = 1'b1;
            if (m_gap > 0) begin
                m_gap--;
                r = 1'b0;
            end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
                m_gap = $urandom_range(1, 12) - 1;
                r = 1'b0;
            end
            m_tready <= r;
        end
    end

    always @(posedge aclk) begin
        logic [32:0] want;
        if (aresetn && s_tvalid && s_tready) begin
            s_took = 1'b1;
            queries_sent++;
            expected_counts.push_back(gcd_pair_count(query_t'(s_tdata)));
        end
        if (aresetn && m_tvalid && m_tready) begin
            counts_seen++;
            if (expected_counts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, m_tdata[32:0]);
                errors++;
            end else begin
                want = expected_counts.pop_front();
                if (m_tdata[32:0] !== want || m_tdata[39:33] !== '0) begin
                    $display("%0t: pair_count mismatch, expected %0d, actual %0d (tdata %h)",
                             $time, want, m_tdata[32:0], m_tdata);
                    errors++;
                end
            end
        end
    end

    initial begin
        int a, b, c, d, k, sel;
        build_mertens();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: extremes and the special cases
        pending_queries.push_back(mk(1, 1, 1, 1, 1));
        pending_queries.push_back(mk(0, 10, 0, 10, 1));
        pending_queries.push_back(mk(0, 0, 0, 0, 1));
        pending_queries.push_back(mk(1, 10, 1, 10, 0));
        pending_queries.push_back(mk(20, 10, 1, 10, 1));
        pending_queries.push_back(mk(1, 10, 20, 10, 1));
        pending_queries.push_back(mk(1, 65535, 1, 65535, 65535));
        pending_queries.push_back(mk(65535, 65535, 65535, 65535, 65535));
        pending_queries.push_back(mk(65535, 65535, 65535, 65535, 1));
        pending_queries.push_back(mk(1, 65535, 1, 65535, 1));
        pending_queries.push_back(mk(32768, 65535, 1, 1000, 3));
        pending_queries.push_back(mk(2, 100, 3, 50, 2));
        pending_queries.push_back(mk(10, 20, 10, 20, 7));
        pending_queries.push_back(mk(1, 300, 1, 300, 400));
        pending_queries.push_back(mk(43690, 21845, 1, 65535, 21845));
        pending_queries.push_back(mk(1, 65534, 1, 65534, 32767));
        // random: small quotients keep each query cheap
        for (int n = 0; n < 84; n++) begin
            sel = $urandom_range(0, 19);
            if (sel < 13) begin
                rand_range(400, a, b);
                rand_range(400, c, d);
                k = $urandom_range(1, $urandom_range(1, 30));
            end else if (sel < 19) begin
                rand_range(65535, a, b);
                rand_range(65535, c, d);
                k = $urandom_range(256, 65535);
            end else begin
                rand_range(200, a, b);
                rand_range(200, c, d);
                k = $urandom_range(0, 1);
            end
            pending_queries.push_back(mk(a, b, c, d, k));
        end
        fill_done = 1'b1;
        running = 1'b1;
        wait (pending_queries.size() == 0);
        @(posedge aclk);
        wait (!s_tvalid);
        wait (expected_counts.size() == 0);
        repeat (200) @(posedge aclk);
        $display("%0d queries sent, %0d counts checked, bounds from empty to full range,",
                 queries_sent, counts_seen);
        $display("divisors from zero to the maximum, with random stalls on both channels");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_counts.size());
        $display("Verification failed");
        $finish;
    end
endmodule
